FILE: sv/plcr_pkg.sv
// ============================================================================
// plcr_pkg
// Shared constants, register codes, pipeline stage map and types for the
// piecewise linear color ramp.
// ============================================================================
package plcr_pkg;

   // sizing
   localparam int MAX_STOPS       = 5;
   localparam int FRACTION_BITS   = 12;
   localparam int NUM_COLORS      = 5;
   localparam int NUM_CHANS       = 3;
   localparam int SAMPLE_W        = 16;
   localparam int BOUND_W         = 16;
   localparam int COUNT_W         = 3;
   localparam int COLOR_W         = 24;
   localparam int CHAN_W          = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 24;

   // divider widths
   localparam int DEN_W           = BOUND_W;
   localparam int KW              = $clog2(MAX_STOPS);
   localparam int QW              = (MAX_STOPS > 2) ? $clog2(MAX_STOPS - 1) : 1;
   localparam int N_W             = DEN_W + QW;
   localparam int STEPS_PER_STAGE = 2;
   localparam int FRAC_STAGES     = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // interpolation widths
   localparam int DELTA_W         = CHAN_W + 1;
   localparam int PROD_W          = DELTA_W + FRACTION_BITS + 1;

   // pipeline stage map
   localparam int ST_P0           = 0;
   localparam int ST_P1           = 1;
   localparam int ST_Q0           = 2;
   localparam int ST_F0           = ST_Q0 + QW;
   localparam int ST_L0           = ST_F0 + FRAC_STAGES;
   localparam int ST_L1           = ST_L0 + 1;
   localparam int ST_OUT          = ST_L1 + 1;
   localparam int NUM_STAGES      = ST_OUT + 1;

   // register codes
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT      = 3'd2;
   localparam int                   CSR_COLOR_BASE = 3;

   // stop count limits
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd5;
   localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_STOPS);
   localparam logic [COUNT_W-1:0] MIN_COUNT   = 3'd1;

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [COLOR_W-1:0] color_type;

   // divider result handed to the interpolation stages
   typedef struct packed {
      logic                     ok;
      logic [QW-1:0]            quo;
      logic [FRACTION_BITS-1:0] frac;
   } div_result_type;

endpackage

FILE: sv/plcr_div.sv
// ============================================================================
// plcr_div
// Pipelined restoring divider: segment index bits, then fraction bits, two per stage.
// The user must hold the span steady while items are in flight; it is not enforced.
// ============================================================================
module plcr_div (
   input  logic                            clock,
   input  logic [plcr_pkg::NUM_STAGES-1:0] stage_en,
   input  logic                            ok_in,
   input  logic [plcr_pkg::N_W-1:0]        num_in,
   input  logic [plcr_pkg::DEN_W-1:0]      den,
   output plcr_pkg::div_result_type        result
);
   import plcr_pkg::*;

   logic [N_W-1:0]           q_rem_ff  [QW];
   logic [QW-1:0]            q_bits_ff [QW];
   logic                     q_ok_ff   [QW];

   logic [DEN_W-1:0]         f_rem_ff  [FRAC_STAGES];
   logic [FRACTION_BITS-1:0] f_bits_ff [FRAC_STAGES];
   logic [QW-1:0]            f_quo_ff  [FRAC_STAGES];
   logic                     f_ok_ff   [FRAC_STAGES];

   // quotient stages, most significant bit first
   for (genvar j = 0; j < QW; j++) begin : g_quo
      localparam int B = QW - 1 - j;
      logic [N_W-1:0] rem_prev;
      logic [N_W-1:0] dsh;
      logic [N_W-1:0] rem_in;
      logic [QW-1:0]  bits_prev;
      logic [QW-1:0]  bits_in;
      logic           ok_prev;
      logic           take;

      if (j == 0) begin : g_first
         assign rem_prev  = num_in;
         assign bits_prev = '0;
         assign ok_prev   = ok_in;
      end else begin : g_next
         assign rem_prev  = q_rem_ff[j-1];
         assign bits_prev = q_bits_ff[j-1];
         assign ok_prev   = q_ok_ff[j-1];
      end

      // compare against the shifted span and subtract
      always_comb begin
         dsh        = N_W'(den) << B;
         take       = (rem_prev >= dsh);
         rem_in     = take ? (rem_prev - dsh) : rem_prev;
         bits_in    = bits_prev;
         bits_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (stage_en[ST_Q0 + j]) begin
            q_rem_ff[j]  <= rem_in;
            q_bits_ff[j] <= bits_in;
            q_ok_ff[j]   <= ok_prev;
         end
      end
   end

   // fraction stages, remainder stays below the span
   for (genvar s = 0; s < FRAC_STAGES; s++) begin : g_frac
      localparam int LEFT  = FRACTION_BITS - STEPS_PER_STAGE * s;
      localparam int STEPS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;
      logic [DEN_W-1:0]         rem_prev;
      logic [FRACTION_BITS-1:0] bits_prev;
      logic [QW-1:0]            quo_prev;
      logic                     ok_prev;
      logic [DEN_W-1:0]         rem_in;
      logic [FRACTION_BITS-1:0] bits_in;
      logic [DEN_W:0]           dbl;
      logic                     take;

      if (s == 0) begin : g_first
         assign rem_prev  = q_rem_ff[QW-1][DEN_W-1:0];
         assign bits_prev = '0;
         assign quo_prev  = q_bits_ff[QW-1];
         assign ok_prev   = q_ok_ff[QW-1];
      end else begin : g_next
         assign rem_prev  = f_rem_ff[s-1];
         assign bits_prev = f_bits_ff[s-1];
         assign quo_prev  = f_quo_ff[s-1];
         assign ok_prev   = f_ok_ff[s-1];
      end

      // shift in a zero, subtract the span where it fits
      always_comb begin
         rem_in  = rem_prev;
         bits_in = bits_prev;
         dbl     = '0;
         take    = 1'b0;
         for (int t = 0; t < STEPS; t++) begin
            dbl    = {rem_in, 1'b0};
            take   = (dbl >= {1'b0, den});
            rem_in = take ? DEN_W'(dbl - {1'b0, den}) : dbl[DEN_W-1:0];
            bits_in[LEFT - 1 - t] = take;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[ST_F0 + s]) begin
            f_rem_ff[s]  <= rem_in;
            f_bits_ff[s] <= bits_in;
            f_quo_ff[s]  <= quo_prev;
            f_ok_ff[s]   <= ok_prev;
         end
      end
   end

   assign result.ok   = f_ok_ff[FRAC_STAGES-1];
   assign result.quo  = f_quo_ff[FRAC_STAGES-1];
   assign result.frac = f_bits_ff[FRAC_STAGES-1];

endmodule

FILE: sv/plcr_lerp.sv
// ============================================================================
// plcr_lerp
// One color channel: registered delta times fraction, then truncation
// toward zero and the add onto the lower stop.
// ============================================================================
module plcr_lerp (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [plcr_pkg::CHAN_W-1:0]            base,
   input  logic signed [plcr_pkg::DELTA_W-1:0]    delta,
   input  logic [plcr_pkg::FRACTION_BITS-1:0]     frac,
   output logic [plcr_pkg::CHAN_W-1:0]            value
);
   import plcr_pkg::*;

   localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRACTION_BITS) - 1);

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [CHAN_W-1:0]        base_ff;
   logic [PROD_W-1:0]        adj;

   // multiply stage
   assign prod_in = delta * $signed({1'b0, frac});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         base_ff <= base;
      end
   end

   // negative products get a bias so the shift rounds toward zero
   assign adj   = prod_ff + (prod_ff[PROD_W-1] ? TRUNC_BIAS : '0);
   assign value = base_ff + adj[FRACTION_BITS +: CHAN_W];

endmodule

FILE: sv/piecewise_linear_color_ramp_unit.sv
// ============================================================================
// piecewise_linear_color_ramp_unit
// Maps a signed sample to an RGB color by linear interpolation between
// evenly spaced color stops set through the register port.
// ============================================================================
//
//  channel  | direction | ports                              | transfer when
//  ---------+-----------+------------------------------------+---------------------
//  request  | in        | req_valid req_ready req_sample     | req_valid & req_ready
//  response | out       | rsp_valid rsp_ready rsp_red/green/ | rsp_valid & rsp_ready
//           |           | blue rsp_interpolated              |
//  register | in        | csr_we csr_index csr_wdata         | csr_we
//
//  One sample per clock unless the pipeline is full and the response stalls.
//  Stages: offset, range check, then the restoring divider with index bits one
//  per stage and two fraction bits per stage, then color select, multiply and output.
//  Each stage moves forward whenever a later stage has a bubble, so the
//  request side keeps taking samples while a response waits in the output.
//  A response stall with a full pipeline holds every stage; nothing is lost.
//  Synchronous active-high reset clears the valid bits and the configuration registers.
//
module piecewise_linear_color_ramp_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [plcr_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [plcr_pkg::CHAN_W-1:0]            rsp_red,
   output logic [plcr_pkg::CHAN_W-1:0]            rsp_green,
   output logic [plcr_pkg::CHAN_W-1:0]            rsp_blue,
   output logic                                   rsp_interpolated,
   input  logic                                   csr_we,
   input  logic [plcr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [plcr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import plcr_pkg::*;

   // configuration registers
   logic signed [BOUND_W-1:0] lower_ff;
   logic signed [BOUND_W-1:0] upper_ff;
   logic [COUNT_W-1:0]        count_ff;
   color_type                 color_ff [NUM_COLORS];

   // derived settings
   logic [COUNT_W-1:0]        cnt_eff;
   logic signed [BOUND_W:0]   span;
   logic [DEN_W-1:0]          den_mag_in;
   logic [DEN_W-1:0]          den_mag_ff;
   logic [KW-1:0]             k_in;
   logic [KW-1:0]             k_ff;
   logic                      mode_ok_in;
   logic                      mode_ok_ff;

   // pipeline control
   logic [NUM_STAGES-1:0]     valid_ff;
   logic [NUM_STAGES-1:0]     stage_en;

   // front stages
   logic                      den_neg;
   logic signed [SAMPLE_W:0]  sample_x;
   logic signed [SAMPLE_W:0]  lower_x;
   logic signed [SAMPLE_W:0]  p0_s_in;
   logic signed [SAMPLE_W:0]  p0_s_ff;
   logic                      p1_ok_in;
   logic [N_W-1:0]            p1_num_in;
   logic                      p1_ok_ff;
   logic [N_W-1:0]            p1_num_ff;

   div_result_type            div_res;

   // color select stage
   color_type                 color_a;
   color_type                 color_b;
   logic                      l0_ok_ff;
   logic [FRACTION_BITS-1:0]  l0_frac_ff;
   chan_type                  l0_base_ff  [NUM_CHANS];
   logic signed [DELTA_W-1:0] l0_delta_ff [NUM_CHANS];
   logic                      l1_ok_ff;
   chan_type                  lerp_val    [NUM_CHANS];

   // output register
   chan_type                  out_chan_ff [NUM_CHANS];
   logic                      out_interp_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
         count_ff <= COUNT_RESET;
         for (int j = 0; j < NUM_COLORS; j++) begin
            color_ff[j] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWER: lower_ff <= csr_wdata[BOUND_W-1:0];
            CSR_UPPER: upper_ff <= csr_wdata[BOUND_W-1:0];
            CSR_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
               for (int j = 0; j < NUM_COLORS; j++) begin
                  if (csr_index == CSR_IDX_W'(CSR_COLOR_BASE + j)) begin
                     color_ff[j] <= csr_wdata[COLOR_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   // clamp stop count, span magnitude, ramp enable
   always_comb begin
      if (count_ff < MIN_COUNT) begin
         cnt_eff = MIN_COUNT;
      end else if (count_ff > MAX_COUNT) begin
         cnt_eff = MAX_COUNT;
      end else begin
         cnt_eff = count_ff;
      end
      span       = {upper_ff[BOUND_W-1], upper_ff} - {lower_ff[BOUND_W-1], lower_ff};
      den_mag_in = span[BOUND_W] ? DEN_W'(-span) : span[DEN_W-1:0];
      k_in       = KW'(cnt_eff - MIN_COUNT);
      mode_ok_in = (cnt_eff > MIN_COUNT) && (upper_ff != lower_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         den_mag_ff <= '0;
         k_ff       <= '0;
         mode_ok_ff <= 1'b0;
      end else begin
         den_mag_ff <= den_mag_in;
         k_ff       <= k_in;
         mode_ok_ff <= mode_ok_in;
      end
   end

   // a stage advances when any later stage is empty or the output drains
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_en[i] = rsp_ready || ((~valid_ff >> i) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_ready = stage_en[ST_P0];
   assign rsp_valid = valid_ff[ST_OUT];

   // offset from the lower bound, mirrored for a reversed range
   always_comb begin
      den_neg  = (upper_ff < lower_ff);
      sample_x = {req_sample[SAMPLE_W-1], req_sample};
      lower_x  = {lower_ff[BOUND_W-1], lower_ff};
      p0_s_in  = den_neg ? (lower_x - sample_x) : (sample_x - lower_x);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_P0]) begin
         p0_s_ff <= p0_s_in;
      end
   end

   // range check and numerator; in range exactly when 0 <= offset < span
   always_comb begin
      p1_ok_in  = mode_ok_ff && !p0_s_ff[SAMPLE_W] && (p0_s_ff[DEN_W-1:0] < den_mag_ff);
      p1_num_in = N_W'({{KW{1'b0}}, p0_s_ff[DEN_W-1:0]} * {{DEN_W{1'b0}}, k_ff});
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_P1]) begin
         p1_ok_ff  <= p1_ok_in;
         p1_num_ff <= p1_num_in;
      end
   end

   plcr_div u_div (
      .clock    (clock),
      .stage_en (stage_en),
      .ok_in    (p1_ok_ff),
      .num_in   (p1_num_ff),
      .den      (den_mag_ff),
      .result   (div_res)
   );

   // pick the two stops around the segment
   always_comb begin
      color_a = '0;
      color_b = '0;
      for (int j = 0; j < MAX_STOPS - 1; j++) begin
         if (div_res.quo == QW'(j)) begin
            color_a = color_ff[j];
            color_b = color_ff[j + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_L0]) begin
         l0_ok_ff   <= div_res.ok;
         l0_frac_ff <= div_res.frac;
         for (int c = 0; c < NUM_CHANS; c++) begin
            l0_base_ff[c]  <= color_a[CHAN_W * (NUM_CHANS - 1 - c) +: CHAN_W];
            l0_delta_ff[c] <= $signed({1'b0, color_b[CHAN_W * (NUM_CHANS - 1 - c) +: CHAN_W]})
                            - $signed({1'b0, color_a[CHAN_W * (NUM_CHANS - 1 - c) +: CHAN_W]});
         end
      end
   end

   // per-channel multiply and truncate
   for (genvar c = 0; c < NUM_CHANS; c++) begin : g_chan
      plcr_lerp u_lerp (
         .clock (clock),
         .en    (stage_en[ST_L1]),
         .base  (l0_base_ff[c]),
         .delta (l0_delta_ff[c]),
         .frac  (l0_frac_ff),
         .value (lerp_val[c])
      );
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_L1]) begin
         l1_ok_ff <= l0_ok_ff;
      end
   end

   // output register, default to the first stop outside the ramp
   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         out_interp_ff <= l1_ok_ff;
         for (int c = 0; c < NUM_CHANS; c++) begin
            out_chan_ff[c] <= l1_ok_ff ? lerp_val[c]
                            : color_ff[0][CHAN_W * (NUM_CHANS - 1 - c) +: CHAN_W];
         end
      end
   end

   assign rsp_red          = out_chan_ff[0];
   assign rsp_green        = out_chan_ff[1];
   assign rsp_blue         = out_chan_ff[2];
   assign rsp_interpolated = out_interp_ff;

endmodule

FILE: sv/plcr_check.sv
// ============================================================================
// plcr_check
// Port-level checks on the color ramp, attached to the top level by bind.
// ============================================================================
module plcr_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [plcr_pkg::CHAN_W-1:0]     rsp_red,
   input  logic [plcr_pkg::CHAN_W-1:0]     rsp_green,
   input  logic [plcr_pkg::CHAN_W-1:0]     rsp_blue,
   input  logic                            rsp_interpolated,
   input  logic                            csr_we,
   input  logic [plcr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [plcr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import plcr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR0 = CSR_IDX_W'(CSR_COLOR_BASE);

   // shadow of the settings seen on the register port
   logic [COLOR_W-1:0] color0_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [BOUND_W-1:0] lower_ff;
   logic [BOUND_W-1:0] upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color0_ff <= '0;
         count_ff  <= COUNT_RESET;
         lower_ff  <= '0;
         upper_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_COLOR0) begin
            color0_ff <= csr_wdata[COLOR_W-1:0];
         end
         if (csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end
         if (csr_index == CSR_LOWER) begin
            lower_ff <= csr_wdata[BOUND_W-1:0];
         end
         if (csr_index == CSR_UPPER) begin
            upper_ff <= csr_wdata[BOUND_W-1:0];
         end
      end
   end

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_red, rsp_green, rsp_blue,
                                                         rsp_interpolated}))
      else $error("stalled response changed");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an empty output stage never blocks the request side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // the fallback color is the first stop
   a_default_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_interpolated |-> {rsp_red, rsp_green, rsp_blue} == color0_ff)
      else $error("default color differs from first stop");

   // a single stop or an empty range never interpolates
   a_no_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (count_ff <= MIN_COUNT || lower_ff == upper_ff) |-> !rsp_interpolated)
      else $error("interpolated without a ramp");

endmodule

bind piecewise_linear_color_ramp_unit plcr_check u_plcr_check (.*);
